[sv/lez_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lez_pkg
// Shared constants and the result record of the Lorenz escape-time block.
// ----------------------------------------------------------------------------
package lez_pkg;

  localparam int IN_FIELD_W  = 32;
  localparam int IN_DATA_W   = 2 * IN_FIELD_W;
  localparam int CFG_W       = 16;
  localparam int MAG_W       = 27;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_PAD_W   = OUT_DATA_W - CFG_W - MAG_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 16'd256;
  localparam logic [MAG_W-1:0] MAG_MAX   = '1;

  typedef struct packed {
    logic             escaped;
    logic [CFG_W-1:0] iterations;
    logic [MAG_W-1:0] magnitude;
  } lez_result_t;

endpackage
`default_nettype wire

[sv/lez_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lez_front
// Input stage: scales the plane point by 0.1 into the start coordinates.
// ----------------------------------------------------------------------------
module lez_front #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 22
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [lez_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic [2*WORD_WIDTH-1:0]      q_data
);
  import lez_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = F + 8;
  localparam int PW = IN_FIELD_W + CW;
  localparam int SW = (PW > W ? PW : W) + 1;

  localparam logic signed [CW-1:0] TENTH = CW'(((64'd1 << F) + 64'd5) / 64'd10);
  localparam logic signed [W-1:0]  WMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN  = {1'b1, {(W-1){1'b0}}};

  logic                  stg_valid_r;
  logic                  stg_valid_nxt;
  logic signed [W-1:0]   x0_r;
  logic signed [W-1:0]   y0_r;
  logic                  accept;

  function automatic logic signed [W-1:0] scale_sat(input logic signed [IN_FIELD_W-1:0] v);
    logic signed [PW-1:0] p;
    logic signed [SW-1:0] s;
    p = v * TENTH;
    s = SW'(p >>> F);
    if (s > SW'(WMAX)) return WMAX;
    if (s < SW'(WMIN)) return WMIN;
    return W'(s);
  endfunction

  assign in_tready     = !stg_valid_r || q_ready;
  assign accept        = in_tvalid && in_tready;
  assign stg_valid_nxt = accept || (stg_valid_r && !q_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
    if (accept) begin
      x0_r <= scale_sat($signed(in_tdata[IN_FIELD_W-1:0]));
      y0_r <= scale_sat($signed(in_tdata[IN_DATA_W-1:IN_FIELD_W]));
    end
  end

  assign q_valid = stg_valid_r;
  assign q_data  = {y0_r, x0_r};

endmodule
`default_nettype wire

[sv/lez_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lez_queue
// Short FIFO of start points between the input stage and the integrator.
// ----------------------------------------------------------------------------
module lez_queue #(
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);
  import lez_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              push;
  logic              pop;

  assign wr_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[sv/lez_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lez_isqrt
// Iterative integer square root (floor), one result bit per cycle.
// ----------------------------------------------------------------------------
module lez_isqrt #(
  parameter int ROOT_W = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] op,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] op_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic                fits;

  // bring down the next two operand bits and try root*4+1
  assign rem_sh = {rem_r[ROOT_W-1:0], op_r[2*ROOT_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        op_r   <= op;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        op_r   <= op_r << 2;
        rem_r  <= fits ? rem_sh - trial : rem_sh;
        root_r <= ROOT_W'({root_r, fits});
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

[sv/lez_euler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lez_euler
// Integrator: forward Euler Lorenz steps, escape test, final magnitude.
// ----------------------------------------------------------------------------
module lez_euler #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 22,
  parameter int ITER_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  logic [2*WORD_WIDTH-1:0]  q_data,
  input  logic [ITER_WIDTH-1:0]    limit,
  output logic                     res_valid,
  input  logic                     res_ready,
  output lez_pkg::lez_result_t     res
);
  import lez_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int IW  = ITER_WIDTH;
  localparam int CW  = F + 8;
  localparam int RZW = (CW > W ? CW : W) + 1;
  localparam int EW  = (CW > W ? CW : W) + 1;
  localparam int DXW = W + 5;
  localparam int DYW = W + RZW + 1;
  localparam int DZW = (2 * W > CW + W ? 2 * W : CW + W) + 1;
  localparam int SW  = DYW + CW + 1;
  localparam int SH  = F - 16;
  localparam int XW  = (W > SH) ? W - SH : 1;
  localparam int MW  = (XW + 4 > MAG_W) ? XW + 4 : MAG_W + 1;

  localparam logic signed [CW-1:0] DT    = CW'(((64'd1 << F) + 64'd50) / 64'd100);
  localparam logic signed [CW-1:0] BETA  = CW'(((64'd8 << F) + 64'd1) / 64'd3);
  localparam logic signed [CW-1:0] RHO   = CW'(64'd28 << F);
  localparam logic signed [CW-1:0] LIMIT = CW'(64'd100 << F);
  localparam logic signed [W-1:0]  WMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  Z_INIT = (F < W - 1) ? W'(64'd1 << F) : WMAX;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_UPD,
    ST_SQR,
    ST_SUM,
    ST_ROOT,
    ST_OUT
  } state_t;

  state_t                   st_r;
  logic signed [W-1:0]      x_r;
  logic signed [W-1:0]      y_r;
  logic signed [W-1:0]      z_r;
  logic [IW-1:0]            i_r;
  logic [IW-1:0]            lim_r;
  logic signed [W+RZW-1:0]  qxr_r;
  logic signed [2*W-1:0]    qxy_r;
  logic signed [CW+W-1:0]   qbz_r;
  logic signed [DXW-1:0]    dx_r;
  logic [2*XW-1:0]          sqx_r;
  logic [2*XW-1:0]          sqy_r;
  lez_result_t              pend_r;
  lez_result_t              res_r;
  logic                     res_valid_r;
  logic                     hand_over;

  // product stage
  logic signed [RZW-1:0]    rz;
  logic signed [W+RZW-1:0]  mul_xr;
  logic signed [2*W-1:0]    mul_xy;
  logic signed [CW+W-1:0]   mul_bz;
  logic signed [DXW-1:0]    diff;
  logic signed [DXW-1:0]    dx_nxt;
  // update stage
  logic signed [DYW-1:0]    dy;
  logic signed [DZW-1:0]    dz;
  logic signed [DXW+CW-1:0] mx;
  logic signed [DYW+CW-1:0] my;
  logic signed [DZW+CW-1:0] mz;
  logic signed [W-1:0]      x_nxt;
  logic signed [W-1:0]      y_nxt;
  logic signed [W-1:0]      z_nxt;
  logic                     escape;
  logic                     last_step;
  // magnitude
  logic signed [XW-1:0]     x16;
  logic signed [XW-1:0]     y16;
  logic signed [2*XW-1:0]   sqx;
  logic signed [2*XW-1:0]   sqy;
  logic [2*XW-1:0]          sq_sum;
  logic                     sq_start;
  logic                     sq_done;
  logic [XW-1:0]            sq_root;
  logic [MW-1:0]            mag_full;
  logic [MAG_W-1:0]         mag_sat;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > SW'(WMAX)) return WMAX;
    if (v < SW'(WMIN)) return WMIN;
    return W'(v);
  endfunction

  function automatic logic beyond(input logic signed [W-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    return (e > EW'(LIMIT)) || (e < -EW'(LIMIT));
  endfunction

  always_comb begin
    rz     = RZW'(RHO) - RZW'(z_r);
    mul_xr = x_r * rz;
    mul_xy = x_r * y_r;
    mul_bz = BETA * z_r;
    diff   = DXW'(y_r) - DXW'(x_r);
    dx_nxt = (diff <<< 3) + (diff <<< 1);
  end

  always_comb begin
    dy        = DYW'(qxr_r) - DYW'(y_r);
    dz        = DZW'(qxy_r) - DZW'(qbz_r);
    mx        = dx_r * DT;
    my        = dy * DT;
    mz        = dz * DT;
    x_nxt     = sat_w(SW'(x_r) + SW'(mx >>> F));
    y_nxt     = sat_w(SW'(y_r) + SW'(my >>> F));
    z_nxt     = sat_w(SW'(z_r) + SW'(mz >>> F));
    escape    = beyond(x_nxt) || beyond(y_nxt) || beyond(z_nxt);
    last_step = (i_r == lim_r - IW'(1));
  end

  always_comb begin
    x16      = XW'(x_r >>> SH);
    y16      = XW'(y_r >>> SH);
    sqx      = x16 * x16;
    sqy      = y16 * y16;
    sq_sum   = sqx_r + sqy_r;
    sq_start = (st_r == ST_SUM);
    mag_full = MW'(sq_root) * MW'(4'd10);
    mag_sat  = (mag_full > MW'(MAG_MAX)) ? MAG_MAX : MAG_W'(mag_full);
  end

  lez_isqrt #(
    .ROOT_W(XW)
  ) u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .op   (sq_sum),
    .done (sq_done),
    .root (sq_root)
  );

  assign q_ready   = (st_r == ST_IDLE);
  assign hand_over = (st_r == ST_OUT) && (!res_valid_r || res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if (hand_over) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            x_r   <= $signed(q_data[W-1:0]);
            y_r   <= $signed(q_data[2*W-1:W]);
            z_r   <= Z_INIT;
            i_r   <= '0;
            lim_r <= limit;
            st_r  <= (limit == '0) ? ST_SQR : ST_PROD;
          end
        end
        ST_PROD: begin
          qxr_r <= mul_xr >>> F;
          qxy_r <= mul_xy >>> F;
          qbz_r <= mul_bz >>> F;
          dx_r  <= dx_nxt;
          st_r  <= ST_UPD;
        end
        ST_UPD: begin
          x_r <= x_nxt;
          y_r <= y_nxt;
          z_r <= z_nxt;
          if (escape) begin
            pend_r.escaped    <= 1'b1;
            pend_r.iterations <= CFG_W'(i_r);
            pend_r.magnitude  <= '0;
            st_r              <= ST_OUT;
          end else if (last_step) begin
            st_r <= ST_SQR;
          end else begin
            i_r  <= i_r + IW'(1);
            st_r <= ST_PROD;
          end
        end
        ST_SQR: begin
          sqx_r <= sqx;
          sqy_r <= sqy;
          st_r  <= ST_SUM;
        end
        ST_SUM: begin
          st_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_done) begin
            pend_r.escaped    <= 1'b0;
            pend_r.iterations <= CFG_W'(lim_r);
            pend_r.magnitude  <= mag_sat;
            st_r              <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hand over once the result register is free
          if (hand_over) begin
            res_r <= pend_r;
            st_r  <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_UPD) |-> (i_r < lim_r))
    else $error("euler step index past limit");

  a_escaped_no_mag: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.escaped) |-> (res_r.magnitude == '0))
    else $error("escaped result carries a magnitude");

  a_root_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (st_r == ST_ROOT))
    else $error("square root finished outside its wait state");

  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_OUT) && (!res_valid_r || res_ready)) |=> (res_valid_r && (st_r == ST_IDLE)))
    else $error("result not handed over");

endmodule
`default_nettype wire

[sv/lorenz_escape_time.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lorenz_escape_time
// Lorenz escape-time test of one plane point per transaction.
//
//   channel | dir | fields (lowest bit first)
//   --------+-----+------------------------------------------------------
//   in_     | in  | tdata: point_re[31:0], point_im[63:32]
//   out_    | out | tdata: iterations[15:0], magnitude[42:16], zero pad
//           |     | tuser: escaped[0]
//   cfg_    | in  | data: max_iterations[15:0]
//
// each Euler step passes a product stage and an update stage; a point that
// does not escape then adds the square root (one bit per cycle).
// synchronous active-low reset; max_iterations resets to 256, no clearing pass.
// the input stage and a two-entry queue take new points while the integrator
// runs, and the result register lets the integrator finish while out_ stalls.
// ----------------------------------------------------------------------------
module lorenz_escape_time #(
  parameter int FRAC_BITS  = 22,
  parameter int WORD_WIDTH = 32,
  parameter int ITER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // point_re, point_im
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lez_pkg::IN_DATA_W-1:0]  in_tdata,
  // iterations, magnitude, pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lez_pkg::OUT_DATA_W-1:0] out_tdata,
  // escaped
  output logic [0:0]                     out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lez_pkg::CFG_W-1:0]      cfg_data
);
  import lez_pkg::*;

  localparam int LIM_W = (ITER_WIDTH < CFG_W) ? ITER_WIDTH : CFG_W;

  logic [CFG_W-1:0]        cfg_r;
  logic [ITER_WIDTH-1:0]   limit;
  logic                    q_in_valid;
  logic                    q_in_ready;
  logic [2*WORD_WIDTH-1:0] q_in_data;
  logic                    q_out_valid;
  logic                    q_out_ready;
  logic [2*WORD_WIDTH-1:0] q_out_data;
  lez_result_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  // bits above the counter width are ignored
  assign limit = ITER_WIDTH'(cfg_r[LIM_W-1:0]);

  lez_front #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_data   (q_in_data)
  );

  lez_queue #(
    .DATA_W(2 * WORD_WIDTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(q_in_valid),
    .wr_ready(q_in_ready),
    .wr_data (q_in_data),
    .rd_valid(q_out_valid),
    .rd_ready(q_out_ready),
    .rd_data (q_out_data)
  );

  lez_euler #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .ITER_WIDTH(ITER_WIDTH)
  ) u_euler (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_out_valid),
    .q_ready  (q_out_ready),
    .q_data   (q_out_data),
    .limit    (limit),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res.magnitude, res.iterations};
  assign out_tuser = res.escaped;

endmodule
`default_nettype wire
